// ----- rtl/aalu_pkg.sv -----
// Shared types and opcode codes for the 8-bit accumulator ALU.
// No dependencies; imported by aalu_core and accumulator_alu_with_flags.
package aalu_pkg;

  // Operation codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_ADC  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SBC  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_XOR  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_CP   = 4'd7;
  localparam logic [3:0] OP_INC  = 4'd8;
  localparam logic [3:0] OP_DEC  = 4'd9;
  localparam logic [3:0] OP_RLCA = 4'd10;
  localparam logic [3:0] OP_RLA  = 4'd11;
  localparam logic [3:0] OP_LOAD = 4'd12;

  // Z, N, H, C flag set
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } aalu_flags_t;

  // Outcome of one operation
  typedef struct packed {
    logic [7:0]  res;
    logic [7:0]  acc;
    aalu_flags_t flags;
  } aalu_out_t;

endpackage

// ----- rtl/aalu_core.sv -----
// Combinational ALU: one operation on the accumulator, operand and flags.
// Depends on aalu_pkg for opcodes and the flag/result structs.
module aalu_core
  import aalu_pkg::*;
(
  input  logic [3:0]  opcode,
  input  logic [7:0]  operand,
  input  logic [7:0]  acc,
  input  aalu_flags_t flags,
  output aalu_out_t   alu_out
);

  logic       cin;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] dif9;
  logic [4:0] hdif5;
  logic [7:0] inc8;
  logic [7:0] dec8;

  // carry-in only for the with-carry forms
  assign cin = ((opcode == OP_ADC) || (opcode == OP_SBC)) ? flags.c : 1'b0;

  // Shared adder and subtractor, with nibble copies for the half carry
  assign sum9  = {1'b0, acc} + {1'b0, operand} + {8'd0, cin};
  assign hsum5 = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
  assign dif9  = {1'b0, acc} - {1'b0, operand} - {8'd0, cin};
  assign hdif5 = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, cin};
  assign inc8  = operand + 8'd1;
  assign dec8  = operand - 8'd1;

  always_comb begin
    alu_out.acc   = acc;
    alu_out.flags = flags;
    alu_out.res   = acc;
    case (opcode)
      OP_ADD, OP_ADC: begin
        alu_out.acc   = sum9[7:0];
        alu_out.flags = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: hsum5[4], c: sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        alu_out.acc   = dif9[7:0];
        alu_out.flags = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      OP_CP: begin
        alu_out.flags = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: hdif5[4], c: dif9[8]};
      end
      OP_AND: begin
        alu_out.acc   = acc & operand;
        alu_out.flags = '{z: ((acc & operand) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        alu_out.acc   = acc ^ operand;
        alu_out.flags = '{z: ((acc ^ operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        alu_out.acc   = acc | operand;
        alu_out.flags = '{z: ((acc | operand) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC: begin
        // accumulator untouched, carry kept
        alu_out.flags = '{z: (inc8 == 8'd0), n: 1'b0, h: (operand[3:0] == 4'hF),
                          c: flags.c};
      end
      OP_DEC: begin
        alu_out.flags = '{z: (dec8 == 8'd0), n: 1'b1, h: (operand[3:0] == 4'h0),
                          c: flags.c};
      end
      OP_RLCA: begin
        alu_out.acc   = {acc[6:0], acc[7]};
        alu_out.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
      end
      OP_RLA: begin
        alu_out.acc   = {acc[6:0], flags.c};
        alu_out.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: acc[7]};
      end
      OP_LOAD: begin
        alu_out.acc = operand;
      end
      default: begin
        // unused codes: no operation
        alu_out.acc = acc;
      end
    endcase

    // inc/dec report the operand result, everything else the new accumulator
    if (opcode == OP_INC) begin
      alu_out.res = inc8;
    end else if (opcode == OP_DEC) begin
      alu_out.res = dec8;
    end else begin
      alu_out.res = alu_out.acc;
    end
  end

endmodule

// ----- rtl/accumulator_alu_with_flags.sv -----
// 8-bit accumulator ALU with Z/N/H/C flags: input register, ALU, result register.
// Words pass the input register, then the result register; throughput one word per cycle
// unless the output stalls, set by the single accumulator/flag feedback path through aalu_core.
// The input stage can take one word while a result waits, stalling only when full.
// Reset (rst_n low, synchronous) clears the accumulator, flags and valid bits.
// Depends on aalu_pkg and aalu_core.
module accumulator_alu_with_flags
  import aalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_opcode,
  input  logic [7:0] in_operand,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_result,
  output logic [7:0] out_accumulator,
  output logic       out_zero_flag,
  output logic       out_subtract_flag,
  output logic       out_half_carry_flag,
  output logic       out_carry_flag
);

  logic        in_vld_r;
  logic [3:0]  op_r;
  logic [7:0]  opnd_r;
  logic [7:0]  acc_r;
  aalu_flags_t flags_r;
  logic        out_vld_r;
  aalu_out_t   res_r;
  aalu_out_t   alu_nxt;
  logic        in_take;
  logic        advance;

  // Handshake: advance moves the input word into the result register
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  aalu_core u_core (
    .opcode  (op_r),
    .operand (opnd_r),
    .acc     (acc_r),
    .flags   (flags_r),
    .alu_out (alu_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_opcode;
      opnd_r <= in_operand;
    end
  end

  // Architectural state: accumulator and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      flags_r <= '0;
    end else if (advance) begin
      acc_r   <= alu_nxt.acc;
      flags_r <= alu_nxt.flags;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= alu_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_result          = res_r.res;
  assign out_accumulator     = res_r.acc;
  assign out_zero_flag       = res_r.flags.z;
  assign out_subtract_flag   = res_r.flags.n;
  assign out_half_carry_flag = res_r.flags.h;
  assign out_carry_flag      = res_r.flags.c;

endmodule

// ----- verif/accumulator_alu_with_flags_checker.sv -----
// Checker for the 8-bit accumulator ALU: watches both channels, predicts each result word
// from its own copy of the accumulator and flags, and compares field by field.
// Depends on aalu_pkg for the opcode codes and the flag/result structs.
`timescale 1ns / 1ps

module accumulator_alu_with_flags_checker
  import aalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [3:0] in_opcode,
  input  logic [7:0] in_operand,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_result,
  input  logic [7:0] out_accumulator,
  input  logic       out_zero_flag,
  input  logic       out_subtract_flag,
  input  logic       out_half_carry_flag,
  input  logic       out_carry_flag,
  output int         mismatches,
  output int         results_due
);

  // Predicted accumulator and flags
  logic [7:0]  acc_q;
  aalu_flags_t flags_q;

  aalu_out_t pending_results[$];
  int        fail_total = 0;
  int        due_total  = 0;

  assign mismatches  = fail_total;
  assign results_due = due_total;

  // Apply one operation to the predicted state and return the word it should produce
  function automatic aalu_out_t alu_step(input logic [3:0] op, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] t;
    logic [8:0] wide;
    logic [4:0] nib;
    logic       cin;
    aalu_out_t  o;
    a   = acc_q;
    t   = 8'h00;
    cin = (op == OP_ADC || op == OP_SBC) ? flags_q.c : 1'b0;
    case (op)
      OP_ADD, OP_ADC: begin
        wide    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        nib     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        acc_q   = wide[7:0];
        flags_q = {wide[7:0] == 8'h00, 1'b0, nib[4], wide[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // borrow shows up as the sign bit of the widened difference
        wide    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
        nib     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
        flags_q = {wide[7:0] == 8'h00, 1'b1, nib[4], wide[8]};
        if (op != OP_CP) acc_q = wide[7:0];
      end
      OP_AND: begin
        acc_q   = a & b;
        flags_q = {acc_q == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        acc_q   = a ^ b;
        flags_q = {acc_q == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        acc_q   = a | b;
        flags_q = {acc_q == 8'h00, 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        t       = b + 8'h01;
        flags_q = {t == 8'h00, 1'b0, b[3:0] == 4'hF, flags_q.c};
      end
      OP_DEC: begin
        t       = b - 8'h01;
        flags_q = {t == 8'h00, 1'b1, b[3:0] == 4'h0, flags_q.c};
      end
      OP_RLCA: begin
        acc_q   = {a[6:0], a[7]};
        flags_q = {1'b0, 1'b0, 1'b0, a[7]};
      end
      OP_RLA: begin
        acc_q   = {a[6:0], flags_q.c};
        flags_q = {1'b0, 1'b0, 1'b0, a[7]};
      end
      OP_LOAD: acc_q = b;
      default: ;  // spare opcodes leave everything alone
    endcase
    o.res   = (op == OP_INC || op == OP_DEC) ? t : acc_q;
    o.acc   = acc_q;
    o.flags = flags_q;
    return o;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_total++;
    end
  endtask

  // Compare accepted result words, then queue the prediction for an accepted input word
  always @(posedge clk) begin
    aalu_out_t want;
    if (!rst_n) begin
      acc_q   = 8'h00;
      flags_q = '0;
      pending_results.delete();
      due_total = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: result %0h accumulator %0h",
                 out_result, out_accumulator);
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          check_field("result", want.res, out_result);
          check_field("accumulator", want.acc, out_accumulator);
          check_field("zero_flag", want.flags.z, out_zero_flag);
          check_field("subtract_flag", want.flags.n, out_subtract_flag);
          check_field("half_carry_flag", want.flags.h, out_half_carry_flag);
          check_field("carry_flag", want.flags.c, out_carry_flag);
        end
      end
      if (in_valid && !in_stall) pending_results.push_back(alu_step(in_opcode, in_operand));
      due_total = pending_results.size();
    end
  end

endmodule

// ----- verif/accumulator_alu_with_flags_tb.sv -----
// Testbench top for the 8-bit accumulator ALU: clock, reset, stimulus and verdict.
// Depends on aalu_pkg, the RTL top and accumulator_alu_with_flags_checker.
`timescale 1ns / 1ps

module accumulator_alu_with_flags_tb;
  import aalu_pkg::*;

  // Spare opcodes, decoded as no operation
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd13;
  localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

  localparam int RANDOM_WORDS  = 600;
  localparam int HOLD_CYCLES   = 48;
  localparam int HOLD_WORDS    = 24;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [3:0] in_opcode  = OP_ADD;
  logic [7:0] in_operand = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_result;
  logic [7:0] out_accumulator;
  logic       out_zero_flag;
  logic       out_subtract_flag;
  logic       out_half_carry_flag;
  logic       out_carry_flag;

  int mismatches;
  int results_due;
  int hold_requests = 0;
  int holds_granted = 0;
  int quiet_cycles  = 0;

  accumulator_alu_with_flags dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_operand          (in_operand),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result          (out_result),
    .out_accumulator     (out_accumulator),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag)
  );

  accumulator_alu_with_flags_checker alu_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_operand          (in_operand),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result          (out_result),
    .out_accumulator     (out_accumulator),
    .out_zero_flag       (out_zero_flag),
    .out_subtract_flag   (out_subtract_flag),
    .out_half_carry_flag (out_half_carry_flag),
    .out_carry_flag      (out_carry_flag),
    .mismatches          (mismatches),
    .results_due         (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [3:0] op, input logic [7:0] operand);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_operand <= operand;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [7:0] operand;
    operand = 8'($urandom_range(0, 255));
    // bias toward nibble and byte boundaries
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: operand = 8'h00;
        1: operand = 8'hFF;
        2: operand = 8'h0F;
        default: operand = 8'h80;
      endcase
    end
    send_word(4'($urandom_range(OP_ADD, OP_UNUSED_LAST)), operand);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Receiver: stall pattern that switches mode now and then, plus requested long holds
  initial begin
    int span;
    int mode;
    forever begin
      span = $urandom_range(20, 80);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk);
        if (holds_granted != hold_requests) begin
          holds_granted++;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          out_stall <= 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
          endcase
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sent;
    int burst;
    bit held;
    bit paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: carries, zeros, borrows, every operation and the spare opcodes
    send_word(OP_LOAD, 8'hFF);
    send_word(OP_ADD, 8'h01);
    send_word(OP_ADC, 8'hFF);
    send_word(OP_LOAD, 8'h0F);
    send_word(OP_ADC, 8'h00);
    send_word(OP_SUB, 8'h10);
    send_word(OP_SUB, 8'h01);
    send_word(OP_SBC, 8'hFF);
    send_word(OP_CP, 8'hFF);
    send_word(OP_CP, 8'h00);
    send_word(OP_AND, 8'h0F);
    send_word(OP_XOR, 8'hFF);
    send_word(OP_OR, 8'h00);
    send_word(OP_INC, 8'hFF);
    send_word(OP_INC, 8'h0F);
    send_word(OP_DEC, 8'h00);
    send_word(OP_DEC, 8'h10);
    send_word(OP_LOAD, 8'h80);
    send_word(OP_RLCA, 8'hFF);
    send_word(OP_RLA, 8'h00);
    send_word(OP_RLA, 8'h00);
    send_word(OP_UNUSED_FIRST, 8'h55);
    send_word(OP_UNUSED_FIRST + 4'd1, 8'hAA);
    send_word(OP_UNUSED_LAST, 8'hFF);
    send_word(OP_AND, 8'h00);

    // Random bursts with random gaps
    while (sent < RANDOM_WORDS) begin
      if (!held && sent >= RANDOM_WORDS / 3) begin
        // long receiver hold while words keep coming, so the input backs up
        held = 1'b1;
        hold_requests++;
        repeat (HOLD_WORDS) send_random();
        sent += HOLD_WORDS;
      end
      if (!paused && sent >= 2 * RANDOM_WORDS / 3) begin
        paused = 1'b1;
        drain();
      end
      burst = $urandom_range(1, 16);
      repeat (burst) send_random();
      sent += burst;
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 5));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/aalu_pkg.sv
rtl/aalu_core.sv
rtl/accumulator_alu_with_flags.sv
verif/accumulator_alu_with_flags_checker.sv
verif/accumulator_alu_with_flags_tb.sv
